>>> hw/rtl/dpbc_pkg.sv
// shared types, widths, register codes and reset values of the balance controller
`default_nettype none

package dpbc_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned LimitW   = 15;
  localparam int unsigned AccW     = 32;
  localparam int unsigned SumW     = 36;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned IntegShift = 6;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [GainW-1:0]   gain_t;
  typedef logic        [LimitW-1:0]  limit_t;
  typedef logic signed [AccW-1:0]    acc_t;
  typedef logic signed [SumW-1:0]    sum_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAnglePropGain  = 3'd0,
    CfgAngleIntegGain = 3'd1,
    CfgAngleDerivGain = 3'd2,
    CfgPosPropGain    = 3'd3,
    CfgPosIntegGain   = 3'd4,
    CfgPosDerivGain   = 3'd5,
    CfgAngleTripLimit = 3'd6
  } cfg_reg_e;

  localparam gain_t  AnglePropGainRst  = 16'sd10240;
  localparam gain_t  AngleIntegGainRst = 16'sd0;
  localparam gain_t  AngleDerivGainRst = 16'sd1280;
  localparam gain_t  PosPropGainRst    = 16'sd0;
  localparam gain_t  PosIntegGainRst   = 16'sd0;
  localparam gain_t  PosDerivGainRst   = 16'sd0;
  localparam limit_t AngleTripLimitRst = 15'd2144;

  localparam acc_t AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam acc_t AccMin = {1'b1, {(AccW-1){1'b0}}};

  // clamp a wide signed sum to the accumulator range
  function automatic acc_t sat_acc(input sum_t v);
    acc_t r;
    if (v > SumW'(AccMax)) begin
      r = AccMax;
    end else if (v < SumW'(AccMin)) begin
      r = AccMin;
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dpbc_if.sv
// valid/ready channel interfaces for sensor samples and drive results
`default_nettype none

interface dpbc_in_if;
  import dpbc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t pend_angle;
  sample_t pend_rate;
  sample_t cart_pos;
  sample_t cart_vel;

  modport source (output valid, input ready, output pend_angle, pend_rate, cart_pos, cart_vel);
  modport sink   (input valid, output ready, input pend_angle, pend_rate, cart_pos, cart_vel);
endinterface

interface dpbc_out_if;
  import dpbc_pkg::*;

  logic valid;
  logic ready;
  acc_t drive;
  logic halted;

  modport source (output valid, input ready, output drive, halted);
  modport sink   (input valid, output ready, input drive, halted);
endinterface

`default_nettype wire

>>> hw/rtl/dual_pid_balance_controller.sv
// dual-loop pid balance controller: angle and position loops, trip latch
//
//   channel | dir | transaction                         | handshake
//   --------+-----+-------------------------------------+-------------
//   cfg     | in  | register write (cfg_idx_i, data)    | cfg_we_i
//   in_ch   | in  | pend_angle, pend_rate, pos, vel     | valid/ready
//   out_ch  | out | drive, halted                       | valid/ready
//
// one sample per cycle sustained while out_ch is not stalled; path from input accept:
// input register, then six products (five 16x16, one 16x17), integrator update and
// drive sum into the result register
// reset clears gains to defaults, integrators to zero and the trip latch
// input stalls only while both registers hold a transaction and the result waits
`default_nettype none

module dual_pid_balance_controller (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [dpbc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [dpbc_pkg::CfgDataW-1:0] cfg_data_i,
  dpbc_in_if.sink                      in_ch,
  dpbc_out_if.source                   out_ch
);
  import dpbc_pkg::*;

  // configuration
  gain_t  ang_kp_q, ang_ki_q, ang_kd_q;
  gain_t  pos_kp_q, pos_ki_q, pos_kd_q;
  limit_t trip_lim_q;

  // input stage
  logic    in_vld_q;
  sample_t ang_q, rate_q, pos_q, vel_q;

  // state
  acc_t ang_int_q, ang_int_d;
  acc_t pos_int_q, pos_int_d;
  logic trip_q;

  // result stage
  logic out_vld_q;
  acc_t drive_q, drive_d;
  logic halted_q;

  logic adv;
  logic halt_now;

  logic signed [SampleW:0]       ang_ext;
  logic        [SampleW:0]       ang_mag;
  logic signed [SampleW:0]       pos_neg;
  logic signed [2*GainW-1:0]     ang_ki_prod;
  logic signed [2*GainW:0]       pos_ki_prod;
  logic signed [2*GainW-1:0]     ang_p, ang_d, pos_p, pos_d;
  sum_t                          drive_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_kp_q   <= AnglePropGainRst;
      ang_ki_q   <= AngleIntegGainRst;
      ang_kd_q   <= AngleDerivGainRst;
      pos_kp_q   <= PosPropGainRst;
      pos_ki_q   <= PosIntegGainRst;
      pos_kd_q   <= PosDerivGainRst;
      trip_lim_q <= AngleTripLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAnglePropGain:  ang_kp_q   <= cfg_data_i;
        CfgAngleIntegGain: ang_ki_q   <= cfg_data_i;
        CfgAngleDerivGain: ang_kd_q   <= cfg_data_i;
        CfgPosPropGain:    pos_kp_q   <= cfg_data_i;
        CfgPosIntegGain:   pos_ki_q   <= cfg_data_i;
        CfgPosDerivGain:   pos_kd_q   <= cfg_data_i;
        CfgAngleTripLimit: trip_lim_q <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign adv          = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready  = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      ang_q  <= in_ch.pend_angle;
      rate_q <= in_ch.pend_rate;
      pos_q  <= in_ch.cart_pos;
      vel_q  <= in_ch.cart_vel;
    end
  end

  // trip detection
  always_comb begin
    ang_ext  = {ang_q[SampleW-1], ang_q};
    ang_mag  = ang_ext[SampleW] ? unsigned'(-ang_ext) : unsigned'(ang_ext);
    halt_now = trip_q || (ang_mag > {2'b00, trip_lim_q});
  end

  // integrators, increment floored to q12.20
  always_comb begin
    pos_neg     = -{pos_q[SampleW-1], pos_q};
    ang_ki_prod = ang_ki_q * ang_q;
    pos_ki_prod = (2*GainW+1)'(pos_ki_q) * (2*GainW+1)'(pos_neg);
    ang_int_d   = sat_acc(SumW'(ang_int_q) + SumW'(ang_ki_prod >>> IntegShift));
    pos_int_d   = sat_acc(SumW'(pos_int_q) + SumW'(pos_ki_prod >>> IntegShift));
  end

  // drive = angle loop plus position loop (the position integrator holds -ki*pos and is subtracted)
  always_comb begin
    ang_p     = ang_kp_q * ang_q;
    ang_d     = ang_kd_q * rate_q;
    pos_p     = pos_kp_q * pos_q;
    pos_d     = pos_kd_q * vel_q;
    drive_sum = SumW'(ang_p) + SumW'(ang_d) + SumW'(ang_int_d)
              + SumW'(pos_p) + SumW'(pos_d) - SumW'(pos_int_d);
    drive_d   = halt_now ? '0 : sat_acc(drive_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_int_q <= '0;
      pos_int_q <= '0;
      trip_q    <= 1'b0;
    end else if (adv) begin
      trip_q <= halt_now;
      if (!halt_now) begin
        ang_int_q <= ang_int_d;
        pos_int_q <= pos_int_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      drive_q  <= drive_d;
      halted_q <= halt_now;
    end
  end

  assign out_ch.valid  = out_vld_q;
  assign out_ch.drive  = drive_q;
  assign out_ch.halted = halted_q;

endmodule

`default_nettype wire

>>> hw/rtl/dpbc_checker.sv
// port-level checks for the balance controller, bound to the top level
`default_nettype none

module dpbc_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         in_ready_i,
  input wire                         out_valid_i,
  input wire                         out_ready_i,
  input wire [dpbc_pkg::AccW-1:0]    out_drive_i,
  input wire                         out_halted_i
);
  import dpbc_pkg::*;

  logic seen_halt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && out_halted_i) begin
      seen_halt_q <= 1'b1;
    end
  end

  // halted results carry zero drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_halted_i |-> out_drive_i == '0)
    else $error("halted result with nonzero drive");

  // once a halted transaction went out, every later one is halted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_halt_q |-> out_halted_i)
    else $error("trip latch released without reset");

  // input back-pressure only comes from a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled while output free");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_drive_i)
      && $stable(out_halted_i))
    else $error("stalled result changed");

endmodule

bind dual_pid_balance_controller dpbc_checker u_dpbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_drive_i  (out_ch.drive),
  .out_halted_i (out_ch.halted)
);

`default_nettype wire
